FILE: rtl/core/gscc_pkg.sv
// ----------------------------------------------------------------------------
// gscc_pkg
// Shared codes and constants of the grid segment collision checker.
// ----------------------------------------------------------------------------
package gscc_pkg;

	// result status codes
	localparam logic [2:0] ST_OK    = 3'd0;
	localparam logic [2:0] ST_SHORT = 3'd1;
	localparam logic [2:0] ST_LONG  = 3'd2;
	localparam logic [2:0] ST_HIT   = 3'd3;
	localparam logic [2:0] ST_WROTE = 3'd4;

	// item opcodes
	localparam logic OP_WRITE = 1'b0;
	localparam logic OP_CHECK = 1'b1;

	// register indexes (byte address / 4)
	localparam logic [2:0] REG_ORIGIN_X  = 3'd0;
	localparam logic [2:0] REG_ORIGIN_Y  = 3'd1;
	localparam logic [2:0] REG_CELL_SIZE = 3'd2;
	localparam logic [2:0] REG_GRID_W    = 3'd3;
	localparam logic [2:0] REG_GRID_H    = 3'd4;
	localparam logic [2:0] REG_RADIUS    = 3'd5;

	// 0.3 m in Q16.16 is 19661; its square in Q32.32
	localparam logic [63:0] MIN_LEN_SQ = 64'd386554921;

	localparam logic [30:0] COST_SAT = 31'h7FFF_FFFF;

endpackage

FILE: rtl/core/grid_segment_collision_check.sv
// ----------------------------------------------------------------------------
// grid_segment_collision_check
// Occupancy grid in a one-bit memory; write items set or clear cells, check items walk
// a segment in steps no shorter than one cell size and test each step point against the map.
// ----------------------------------------------------------------------------
//  channel   signals                                    transfer
//  item in   start, busy, opcode, cell_index, ...,to_z  start & !busy
//  result    done, status, path_cost                    done (one cycle)
//  config    psel, penable, pwrite, paddr, pwdata, ...  psel & penable & pwrite
//
// A write item's result appears in the next cycle.
// A check item runs the axis test, then the length tests, then the square root
// iterations and three divisions, then for each step point the advance, the
// point, the bound test, the cell division and one grid memory read, and
// finally the cost.
// After reset a clearing pass writes all MAP_CELLS cells as free; busy
// stays high through it. The receiver cannot stall results.
// ----------------------------------------------------------------------------
module grid_segment_collision_check
	import gscc_pkg::*;
#(
	parameter int MAP_CELLS = 65536,
	parameter int MAX_STEPS = 1024
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic        opcode,
	input  logic [15:0] cell_index,
	input  logic [7:0]  cell_value,
	input  logic [31:0] from_x,
	input  logic [31:0] from_y,
	input  logic [31:0] from_z,
	input  logic [31:0] to_x,
	input  logic [31:0] to_y,
	input  logic [31:0] to_z,
	output logic        done,
	output logic [2:0]  status,
	output logic [30:0] path_cost,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [4:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	localparam int AW = $clog2(MAP_CELLS);
	localparam int SW = $clog2(MAX_STEPS + 1);

	localparam logic [3:0] S_CLEAR = 4'd0;
	localparam logic [3:0] S_IDLE  = 4'd1;
	localparam logic [3:0] S_MAG   = 4'd2;
	localparam logic [3:0] S_SQ    = 4'd3;
	localparam logic [3:0] S_CMP   = 4'd4;
	localparam logic [3:0] S_SQRT  = 4'd5;
	localparam logic [3:0] S_DIV   = 4'd6;
	localparam logic [3:0] S_ADV   = 4'd7;
	localparam logic [3:0] S_PT    = 4'd8;
	localparam logic [3:0] S_BND   = 4'd9;
	localparam logic [3:0] S_CELL  = 4'd10;
	localparam logic [3:0] S_IDX   = 4'd11;
	localparam logic [3:0] S_RD    = 4'd12;
	localparam logic [3:0] S_CHK   = 4'd13;
	localparam logic [3:0] S_COST  = 4'd14;

	// configuration registers
	logic [31:0] origin_x_q, origin_y_q;
	logic [30:0] cell_size_q, radius_q;
	logic [8:0]  grid_w_q, grid_h_q;
	logic        cfg_wr;
	logic [30:0] cell_eff;

	logic [3:0]  state_q;
	logic [AW-1:0] clr_cnt_q;

	// grid memory
	logic          grid_mem [MAP_CELLS];
	logic          mem_we, mem_wd, mem_re, mem_rd_q;
	logic [AW-1:0] mem_wa, mem_ra;
	logic [31:0]   wr_idx_w, chk_idx_w;

	// item registers
	logic [31:0] fx_q, fy_q;
	logic [32:0] dx_q, dy_q, dz_q, dx_in, dy_in, dz_in;
	logic [32:0] magx, magy, magz;
	logic [30:0] ax_q, ay_q, az_q;

	// shared multiplier
	logic [31:0] mul_a, mul_b;
	logic [63:0] mul_p_q;
	logic [2:0]  sq_cnt_q;
	logic [63:0] s_q, r2_q;
	logic signed [41:0] maxx_q, maxy_q, ox42, oy42;

	// square root
	logic [63:0] sq_rem_q, sq_root_q, sq_bit_q, sq_trial, sq_root_n;

	// divider
	logic [1:0]  div_ph_q;
	logic [4:0]  div_cnt_q;
	logic [31:0] div_quo_q, div_rem_q, div_dsr_q, div_quo_n, div_rem_n;
	logic [32:0] div_shift;
	logic        div_ge;

	// step walk
	logic [SW-1:0] steps_q, k_q, drx_q, dry_q, rx_q, ry_q;
	logic [SW:0]   sumx, sumy;
	logic [31:0]   dqx_q, dqy_q, qx_q, qy_q;
	logic signed [41:0] px_q, py_q, px_n, py_n, relx, rely;
	logic [39:0]   cnx_q, cny_q, csh_q;
	logic [8:0]    col_q, row_q;
	logic [3:0]    cdv_cnt_q;

	// result registers
	logic        done_q;
	logic [2:0]  status_q;
	logic [30:0] cost_q;

	assign busy      = (state_q != S_IDLE);
	assign done      = done_q;
	assign status    = status_q;
	assign path_cost = cost_q;
	assign pready    = 1'b1;
	assign cell_eff  = (cell_size_q == 31'd0) ? 31'd1 : cell_size_q;

	// configuration write and read back
	assign cfg_wr = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			origin_x_q  <= 32'd0;
			origin_y_q  <= 32'd0;
			cell_size_q <= 31'd6554;
			grid_w_q    <= 9'd256;
			grid_h_q    <= 9'd256;
			radius_q    <= 31'd655360;
		end else if (cfg_wr) begin
			unique case (paddr[4:2])
				REG_ORIGIN_X:  origin_x_q  <= pwdata;
				REG_ORIGIN_Y:  origin_y_q  <= pwdata;
				REG_CELL_SIZE: cell_size_q <= pwdata[30:0];
				REG_GRID_W:    grid_w_q    <= pwdata[8:0];
				REG_GRID_H:    grid_h_q    <= pwdata[8:0];
				REG_RADIUS:    radius_q    <= pwdata[30:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[4:2])
			REG_ORIGIN_X:  prdata = origin_x_q;
			REG_ORIGIN_Y:  prdata = origin_y_q;
			REG_CELL_SIZE: prdata = {1'b0, cell_size_q};
			REG_GRID_W:    prdata = {23'd0, grid_w_q};
			REG_GRID_H:    prdata = {23'd0, grid_h_q};
			REG_RADIUS:    prdata = {1'b0, radius_q};
			default:       prdata = 32'd0;
		endcase
	end

	// grid memory ports
	assign wr_idx_w  = {16'd0, cell_index};
	assign chk_idx_w = mul_p_q[31:0] + {23'd0, col_q};

	always_comb begin
		mem_we = 1'b0;
		mem_wa = clr_cnt_q;
		mem_wd = 1'b0;
		if (state_q == S_CLEAR) begin
			mem_we = 1'b1;
		end else if (state_q == S_IDLE && start && opcode == OP_WRITE &&
			wr_idx_w < 32'(MAP_CELLS)) begin
			mem_we = 1'b1;
			mem_wa = wr_idx_w[AW-1:0];
			mem_wd = !cell_value[7] && (cell_value != 8'd0);
		end
	end

	assign mem_re = (state_q == S_RD) && (chk_idx_w < 32'(MAP_CELLS));
	assign mem_ra = chk_idx_w[AW-1:0];

	always_ff @(posedge clk) begin
		if (mem_we) begin
			grid_mem[mem_wa] <= mem_wd;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_re) begin
			mem_rd_q <= grid_mem[mem_ra];
		end
	end

	// axis differences and magnitudes
	assign dx_in = {to_x[31], to_x} - {from_x[31], from_x};
	assign dy_in = {to_y[31], to_y} - {from_y[31], from_y};
	assign dz_in = {to_z[31], to_z} - {from_z[31], from_z};
	assign magx  = dx_q[32] ? (~dx_q + 33'd1) : dx_q;
	assign magy  = dy_q[32] ? (~dy_q + 33'd1) : dy_q;
	assign magz  = dz_q[32] ? (~dz_q + 33'd1) : dz_q;

	// multiplier operand select
	always_comb begin
		mul_a = {1'b0, cell_eff};
		mul_b = 32'd0;
		priority if (state_q == S_SQ) begin
			unique case (sq_cnt_q)
				3'd0:    begin mul_a = {1'b0, ax_q};     mul_b = {1'b0, ax_q}; end
				3'd1:    begin mul_a = {1'b0, ay_q};     mul_b = {1'b0, ay_q}; end
				3'd2:    begin mul_a = {1'b0, az_q};     mul_b = {1'b0, az_q}; end
				3'd3:    begin mul_a = {1'b0, radius_q}; mul_b = {1'b0, radius_q}; end
				3'd4:    mul_b = {23'd0, grid_w_q};
				default: mul_b = {23'd0, grid_h_q};
			endcase
		end else if (state_q == S_IDX) begin
			mul_a = {23'd0, row_q};
			mul_b = {23'd0, grid_w_q};
		end else begin
			mul_b = 32'(steps_q);
		end
	end

	always_ff @(posedge clk) begin
		mul_p_q <= mul_a * mul_b;
	end

	// square root iteration
	assign sq_trial  = sq_root_q + sq_bit_q;
	assign sq_root_n = (sq_rem_q >= sq_trial) ? ((sq_root_q >> 1) + sq_bit_q)
		: (sq_root_q >> 1);

	// restoring divider step
	assign div_shift = {div_rem_q, div_quo_q[31]};
	assign div_ge    = div_shift >= {1'b0, div_dsr_q};
	assign div_rem_n = div_ge ? 32'(div_shift - {1'b0, div_dsr_q}) : div_shift[31:0];
	assign div_quo_n = {div_quo_q[30:0], div_ge};

	// step point arithmetic
	assign sumx = {1'b0, rx_q} + {1'b0, drx_q};
	assign sumy = {1'b0, ry_q} + {1'b0, dry_q};
	assign ox42 = $signed({{10{origin_x_q[31]}}, origin_x_q});
	assign oy42 = $signed({{10{origin_y_q[31]}}, origin_y_q});
	assign px_n = $signed({{10{fx_q[31]}}, fx_q}) +
		(dx_q[32] ? -$signed({10'd0, qx_q}) : $signed({10'd0, qx_q}));
	assign py_n = $signed({{10{fy_q[31]}}, fy_q}) +
		(dy_q[32] ? -$signed({10'd0, qy_q}) : $signed({10'd0, qy_q}));
	assign relx = px_q - ox42;
	assign rely = py_q - oy42;

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_CLEAR;
			clr_cnt_q <= '0;
			done_q    <= 1'b0;
			sq_cnt_q  <= 3'd0;
			div_ph_q  <= 2'd0;
			div_cnt_q <= 5'd0;
			cdv_cnt_q <= 4'd0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				S_CLEAR: begin
					clr_cnt_q <= clr_cnt_q + 1'b1;
					if (clr_cnt_q == AW'(MAP_CELLS - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (start) begin
						if (opcode == OP_WRITE) begin
							done_q   <= 1'b1;
							status_q <= ST_WROTE;
							cost_q   <= 31'd0;
						end else begin
							fx_q    <= from_x;
							fy_q    <= from_y;
							dx_q    <= dx_in;
							dy_q    <= dy_in;
							dz_q    <= dz_in;
							state_q <= S_MAG;
						end
					end
				end
				S_MAG: begin
					ax_q <= magx[30:0];
					ay_q <= magy[30:0];
					az_q <= magz[30:0];
					if (magx > {2'b0, radius_q} || magy > {2'b0, radius_q} ||
						magz > {2'b0, radius_q}) begin
						done_q   <= 1'b1;
						status_q <= ST_LONG;
						cost_q   <= 31'd0;
						state_q  <= S_IDLE;
					end else begin
						sq_cnt_q <= 3'd0;
						state_q  <= S_SQ;
					end
				end
				S_SQ: begin
					// collect squares, radius squared and the map extents
					sq_cnt_q <= sq_cnt_q + 3'd1;
					unique case (sq_cnt_q)
						3'd1:    s_q    <= mul_p_q;
						3'd2:    s_q    <= s_q + mul_p_q;
						3'd3:    s_q    <= s_q + mul_p_q;
						3'd4:    r2_q   <= mul_p_q;
						3'd5:    maxx_q <= ox42 + $signed({2'b0, mul_p_q[39:0]});
						3'd6: begin
							maxy_q  <= oy42 + $signed({2'b0, mul_p_q[39:0]});
							state_q <= S_CMP;
						end
						default: ;
					endcase
				end
				S_CMP: begin
					if (s_q > r2_q) begin
						done_q   <= 1'b1;
						status_q <= ST_LONG;
						cost_q   <= 31'd0;
						state_q  <= S_IDLE;
					end else if (s_q < MIN_LEN_SQ) begin
						done_q   <= 1'b1;
						status_q <= ST_SHORT;
						cost_q   <= 31'd0;
						state_q  <= S_IDLE;
					end else begin
						sq_rem_q  <= s_q;
						sq_root_q <= 64'd0;
						sq_bit_q  <= 64'd1 << 62;
						state_q   <= S_SQRT;
					end
				end
				S_SQRT: begin
					if (sq_rem_q >= sq_trial) begin
						sq_rem_q <= sq_rem_q - sq_trial;
					end
					sq_root_q <= sq_root_n;
					sq_bit_q  <= sq_bit_q >> 2;
					if (sq_bit_q[0]) begin
						div_quo_q <= sq_root_n[31:0];
						div_rem_q <= 32'd0;
						div_dsr_q <= {1'b0, cell_eff};
						div_cnt_q <= 5'd0;
						div_ph_q  <= 2'd0;
						state_q   <= S_DIV;
					end
				end
				S_DIV: begin
					div_quo_q <= div_quo_n;
					div_rem_q <= div_rem_n;
					div_cnt_q <= div_cnt_q + 5'd1;
					if (div_cnt_q == 5'd31) begin
						div_cnt_q <= 5'd0;
						div_rem_q <= 32'd0;
						unique case (div_ph_q)
							2'd0: begin
								steps_q <= div_quo_n[SW-1:0];
								if (div_quo_n == 32'd0) begin
									done_q   <= 1'b1;
									status_q <= ST_OK;
									cost_q   <= 31'd0;
									state_q  <= S_IDLE;
								end else if (div_quo_n > 32'(MAX_STEPS)) begin
									done_q   <= 1'b1;
									status_q <= ST_LONG;
									cost_q   <= 31'd0;
									state_q  <= S_IDLE;
								end else begin
									div_quo_q <= {1'b0, ax_q};
									div_dsr_q <= 32'(div_quo_n[SW-1:0]);
									div_ph_q  <= 2'd1;
								end
							end
							2'd1: begin
								dqx_q     <= div_quo_n;
								drx_q     <= div_rem_n[SW-1:0];
								div_quo_q <= {1'b0, ay_q};
								div_ph_q  <= 2'd2;
							end
							default: begin
								dqy_q   <= div_quo_n;
								dry_q   <= div_rem_n[SW-1:0];
								qx_q    <= 32'd0;
								qy_q    <= 32'd0;
								rx_q    <= '0;
								ry_q    <= '0;
								k_q     <= SW'(1);
								state_q <= S_ADV;
							end
						endcase
					end
				end
				S_ADV: begin
					// advance quotient and remainder by one step
					if (sumx >= {1'b0, steps_q}) begin
						rx_q <= SW'(sumx - {1'b0, steps_q});
						qx_q <= qx_q + dqx_q + 32'd1;
					end else begin
						rx_q <= sumx[SW-1:0];
						qx_q <= qx_q + dqx_q;
					end
					if (sumy >= {1'b0, steps_q}) begin
						ry_q <= SW'(sumy - {1'b0, steps_q});
						qy_q <= qy_q + dqy_q + 32'd1;
					end else begin
						ry_q <= sumy[SW-1:0];
						qy_q <= qy_q + dqy_q;
					end
					state_q <= S_PT;
				end
				S_PT: begin
					px_q    <= px_n;
					py_q    <= py_n;
					state_q <= S_BND;
				end
				S_BND: begin
					if (px_q <= ox42 || px_q >= maxx_q || py_q <= oy42 || py_q >= maxy_q)
					begin
						done_q   <= 1'b1;
						status_q <= ST_HIT;
						cost_q   <= 31'd0;
						state_q  <= S_IDLE;
					end else begin
						cnx_q     <= relx[39:0];
						cny_q     <= rely[39:0];
						csh_q     <= {1'b0, cell_eff, 8'd0};
						cdv_cnt_q <= 4'd0;
						state_q   <= S_CELL;
					end
				end
				S_CELL: begin
					// one column bit and one row bit a cycle
					if (cnx_q >= csh_q) begin
						cnx_q <= cnx_q - csh_q;
					end
					if (cny_q >= csh_q) begin
						cny_q <= cny_q - csh_q;
					end
					col_q     <= {col_q[7:0], cnx_q >= csh_q};
					row_q     <= {row_q[7:0], cny_q >= csh_q};
					csh_q     <= csh_q >> 1;
					cdv_cnt_q <= cdv_cnt_q + 4'd1;
					if (cdv_cnt_q == 4'd8) begin
						state_q <= S_IDX;
					end
				end
				S_IDX: begin
					state_q <= S_RD;
				end
				S_RD: begin
					if (!mem_re) begin
						done_q   <= 1'b1;
						status_q <= ST_HIT;
						cost_q   <= 31'd0;
						state_q  <= S_IDLE;
					end else begin
						state_q <= S_CHK;
					end
				end
				S_CHK: begin
					if (mem_rd_q) begin
						done_q   <= 1'b1;
						status_q <= ST_HIT;
						cost_q   <= 31'd0;
						state_q  <= S_IDLE;
					end else if (k_q == steps_q) begin
						state_q <= S_COST;
					end else begin
						k_q     <= k_q + 1'b1;
						state_q <= S_ADV;
					end
				end
				S_COST: begin
					done_q   <= 1'b1;
					status_q <= ST_OK;
					cost_q   <= (mul_p_q[63:31] != 33'd0) ? COST_SAT : mul_p_q[30:0];
					state_q  <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

FILE: sim/grid_segment_collision_check_checker.sv
// ----------------------------------------------------------------------------
// grid_segment_collision_check_checker
// Watches the item and result channels of the collision checker, keeps its own
// copy of the grid and registers, predicts each result and compares it.
// ----------------------------------------------------------------------------
module grid_segment_collision_check_checker
	import gscc_pkg::*;
#(
	parameter int MAP_CELLS = 65536,
	parameter int MAX_STEPS = 1024
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic        busy,
	input  logic        opcode,
	input  logic [15:0] cell_index,
	input  logic [7:0]  cell_value,
	input  logic [31:0] from_x,
	input  logic [31:0] from_y,
	input  logic [31:0] from_z,
	input  logic [31:0] to_x,
	input  logic [31:0] to_y,
	input  logic [31:0] to_z,
	input  logic        done,
	input  logic [2:0]  status,
	input  logic [30:0] path_cost,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [4:0]  paddr,
	input  logic [31:0] pwdata,
	input  logic        pready,
	output int          mismatches,
	output int          pending,
	output logic        accepted
);

	typedef struct packed {
		logic [2:0]  status;
		logic [30:0] cost;
	} outcome_t;

	localparam longint MIN_LEN = 19661;

	logic            occ[MAP_CELLS];
	longint          org_x, org_y;
	longint unsigned cell_q, width_q, height_q, radius_q;
	outcome_t        expected_outcomes[$];

	function automatic longint unsigned mag64(longint v);
		return v < 0 ? longint'(-v) : longint'(v);
	endfunction

	function automatic longint unsigned root64(longint unsigned s);
		longint unsigned r, b;
		r = 0;
		b = 64'd1 << 62;
		while (b > s) b >>= 2;
		while (b != 0) begin
			if (s >= r + b) begin
				s -= r + b;
				r = (r >> 1) + b;
			end else begin
				r >>= 1;
			end
			b >>= 2;
		end
		return r;
	endfunction

	function automatic longint step_offset(longint d, longint unsigned k, longint unsigned n);
		longint unsigned q;
		q = (mag64(d) * k) / n;
		return d < 0 ? -longint'(q) : longint'(q);
	endfunction

	function automatic bit point_blocked(longint x, longint y, longint unsigned c);
		longint mx, my;
		longint unsigned col, row, idx;
		mx = org_x + longint'(c * width_q);
		my = org_y + longint'(c * height_q);
		if (x <= org_x || x >= mx || y <= org_y || y >= my) return 1;
		col = longint'(x - org_x) / c;
		row = longint'(y - org_y) / c;
		idx = col + row * width_q;
		if (idx >= MAP_CELLS) return 1;
		return occ[idx];
	endfunction

	// walk the segment as the block does and produce its outcome
	function automatic outcome_t predict_segment();
		outcome_t        o;
		longint          fx, fy, dx, dy, dz;
		longint unsigned ax, ay, az, s, c, n, cost;
		o = '0;
		fx = longint'(signed'(from_x));
		fy = longint'(signed'(from_y));
		dx = longint'(signed'(to_x)) - fx;
		dy = longint'(signed'(to_y)) - fy;
		dz = longint'(signed'(to_z)) - longint'(signed'(from_z));
		ax = mag64(dx);
		ay = mag64(dy);
		az = mag64(dz);
		if (ax > radius_q || ay > radius_q || az > radius_q) begin
			o.status = ST_LONG;
			return o;
		end
		s = ax * ax + ay * ay + az * az;
		if (s > radius_q * radius_q) begin
			o.status = ST_LONG;
			return o;
		end
		if (s < MIN_LEN * MIN_LEN) begin
			o.status = ST_SHORT;
			return o;
		end
		c = cell_q == 0 ? 1 : cell_q;
		n = root64(s) / c;
		if (n == 0) begin
			o.status = ST_OK;
			return o;
		end
		if (n > MAX_STEPS) begin
			o.status = ST_LONG;
			return o;
		end
		for (longint unsigned k = 1; k <= n; k++) begin
			if (point_blocked(fx + step_offset(dx, k, n), fy + step_offset(dy, k, n), c)) begin
				o.status = ST_HIT;
				return o;
			end
		end
		cost = n * c;
		if (cost > COST_SAT) cost = COST_SAT;
		o.status = ST_OK;
		o.cost = cost[30:0];
		return o;
	endfunction

	assign pending  = expected_outcomes.size();
	assign accepted = (start && !busy) || done;

	always @(posedge clk or negedge arst_n) begin
		outcome_t o;
		if (!arst_n) begin
			foreach (occ[i]) occ[i] = 1'b0;
			org_x = 0;
			org_y = 0;
			cell_q = 6554;
			width_q = 256;
			height_q = 256;
			radius_q = 655360;
			mismatches = 0;
			expected_outcomes.delete();
		end else begin
			// compare a result against the oldest expectation
			if (done) begin
				if (expected_outcomes.size() == 0) begin
					if (mismatches < 10) $display("unexpected result status %0d", status);
					mismatches++;
				end else begin
					o = expected_outcomes.pop_front();
					if (o.status !== status || o.cost !== path_cost) begin
						if (mismatches < 10)
							$display("result mismatch: status exp %0d got %0d, cost exp %0d got %0d",
								o.status, status, o.cost, path_cost);
						mismatches++;
					end
				end
			end
			// register writes
			if (psel && penable && pwrite && pready) begin
				case (paddr[4:2])
					REG_ORIGIN_X:  org_x = longint'(signed'(pwdata));
					REG_ORIGIN_Y:  org_y = longint'(signed'(pwdata));
					REG_CELL_SIZE: cell_q = pwdata[30:0];
					REG_GRID_W:    width_q = pwdata[8:0];
					REG_GRID_H:    height_q = pwdata[8:0];
					REG_RADIUS:    radius_q = pwdata[30:0];
					default: ;
				endcase
			end
			// item transfer
			if (start && !busy) begin
				if (opcode == OP_WRITE) begin
					if (cell_index < MAP_CELLS)
						occ[cell_index] = !cell_value[7] && cell_value != 0;
					o = '0;
					o.status = ST_WROTE;
				end else begin
					o = predict_segment();
				end
				// append at the tail
				expected_outcomes = {expected_outcomes, o};
			end
		end
	end

endmodule

FILE: sim/grid_segment_collision_check_test.sv
// ----------------------------------------------------------------------------
// grid_segment_collision_check_test
// Drives cell writes and segment checks through several map settings, with
// bursty stimulus and pauses; the checker predicts and compares every result.
// ----------------------------------------------------------------------------
module grid_segment_collision_check_test;
	import gscc_pkg::*;

	localparam int WATCHDOG = 400000;

	logic        clk = 0;
	logic        arst_n = 0;
	logic        start = 0;
	logic        busy;
	logic        opcode = 0;
	logic [15:0] cell_index = 0;
	logic [7:0]  cell_value = 0;
	logic [31:0] from_x = 0, from_y = 0, from_z = 0, to_x = 0, to_y = 0, to_z = 0;
	logic        done;
	logic [2:0]  status;
	logic [30:0] path_cost;
	logic        psel = 0, penable = 0, pwrite = 0;
	logic [4:0]  paddr = 0;
	logic [31:0] pwdata = 0;
	logic [31:0] prdata;
	logic        pready;
	int          mismatches, pending;
	logic        accepted;
	int          idle_cycles = 0;

	// map settings held by the test for aiming segments
	int          cfg_cell = 6554, cfg_w = 256, cfg_h = 256, cfg_ox = 0, cfg_oy = 0;

	always #5 clk = ~clk;

	grid_segment_collision_check dut (.*);
	grid_segment_collision_check_checker chk (.*);

	// watchdog on cycles without any transfer
	always @(posedge clk) begin
		idle_cycles = accepted ? 0 : idle_cycles + 1;
		if (idle_cycles >= WATCHDOG) begin
			$display("Mismatches found");
			$finish;
		end
	end

	task automatic reg_write(input logic [2:0] idx, input logic [31:0] v);
		@(negedge clk);
		psel = 1; pwrite = 1; penable = 0; paddr = {idx, 2'b00}; pwdata = v;
		@(negedge clk);
		penable = 1;
		@(negedge clk);
		psel = 0; penable = 0; pwrite = 0;
	endtask

	// wait for every result, then let a straggler finish
	task automatic drain();
		while (pending != 0) @(negedge clk);
		repeat (20) @(negedge clk);
	endtask

	task automatic configure(input int ox, oy, cs, w, h, rad);
		drain();
		reg_write(REG_ORIGIN_X, ox);
		reg_write(REG_ORIGIN_Y, oy);
		reg_write(REG_CELL_SIZE, cs);
		reg_write(REG_GRID_W, w);
		reg_write(REG_GRID_H, h);
		reg_write(REG_RADIUS, rad);
		cfg_ox = ox; cfg_oy = oy; cfg_cell = cs; cfg_w = w; cfg_h = h;
	endtask

	// hold an item until its transfer
	task automatic send(input logic op, input logic [15:0] ci, input logic [7:0] cv,
			input logic [31:0] fx, fy, fz, tx, ty, tz);
		start = 1; opcode = op; cell_index = ci; cell_value = cv;
		from_x = fx; from_y = fy; from_z = fz; to_x = tx; to_y = ty; to_z = tz;
		@(posedge clk);
		while (busy) @(posedge clk);
		@(negedge clk);
		start = 0;
	endtask

	task automatic put_cell(input logic [15:0] ci, input logic [7:0] cv);
		send(OP_WRITE, ci, cv, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
	endtask

	task automatic check(input logic [31:0] fx, fy, fz, tx, ty, tz);
		send(OP_CHECK, 16'($urandom), 8'($urandom), fx, fy, fz, tx, ty, tz);
	endtask

	// random point within the configured map, its edges included
	function automatic logic [31:0] in_map(input int org, input int cells);
		return org + int'($urandom_range(0, cells * cfg_cell));
	endfunction

	task automatic random_item();
		logic [31:0] fx, fy, fz;
		int span;
		case ($urandom_range(0, 9))
			0, 1, 2: put_cell(16'($urandom_range(0, cfg_w * cfg_h)), 8'($urandom));
			3: check($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
			default: begin
				span = cfg_cell * $urandom_range(1, 40);
				fx = in_map(cfg_ox, cfg_w);
				fy = in_map(cfg_oy, cfg_h);
				fz = $urandom;
				check(fx, fy, fz, fx + $urandom_range(0, span) - span / 2,
					fy + $urandom_range(0, span) - span / 2,
					fz + $urandom_range(0, span / 4) - span / 8);
			end
		endcase
	endtask

	task automatic random_phase(input int count);
		int left;
		left = count;
		while (left > 0) begin
			for (int b = $urandom_range(1, 12); b > 0 && left > 0; b--) begin
				random_item();
				left--;
			end
			if ($urandom_range(0, 3) != 0) repeat ($urandom_range(0, 15)) @(negedge clk);
		end
	endtask

	initial begin
		repeat (10) @(negedge clk);
		arst_n = 1;
		@(negedge clk);

		// directed: writes at the field extremes, then special segments
		put_cell(16'd0, 8'd127);
		put_cell(16'hFFFF, 8'h80);
		put_cell(16'd0, 8'd0);
		put_cell(16'd300, 8'd1);
		put_cell(16'd301, 8'hFF);
		check(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
			32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
		check(32'd65536, 32'd65536, 0, 32'd65536 + 100, 32'd65536, 0);
		check(32'd65536, 32'd65536, 0, 32'd65536 + 19661, 32'd65536, 0);
		check(32'd65536, 32'd65536, 0, 32'd65536 + 200000, 32'd65536 + 100000, 0);
		check(32'd65536, 32'd6554 * 2, 0, 32'd65536, 32'd6554 * 2 + 300000, 0);
		check(32'd1000, 32'd1000, 0, 32'd1000, 32'd1000, 32'd400000);
		check(32'hFFFF_0000, 32'd65536, 0, 32'd100000, 32'd65536, 0);
		// radius below 0.3 m, then zero steps with a huge cell
		configure(0, 0, 6554, 256, 256, 100);
		check(0, 0, 0, 5, 0, 0);
		configure(0, 0, 32'h7FFF_FFFF, 256, 256, 32'h7FFF_FFFF);
		check(32'd65536, 32'd65536, 0, 32'd65536 + 30000, 32'd65536, 0);
		// too many steps and a zero cell size
		configure(0, 0, 1, 256, 256, 655360);
		check(32'd10, 32'd10, 0, 32'd30000, 32'd10, 0);
		check(32'd10, 32'd10, 0, 32'd20, 32'd19661 + 10, 0);
		configure(0, 0, 0, 256, 256, 655360);
		check(32'd10, 32'd10, 0, 32'd30000, 32'd10, 0);
		// zero width and height
		configure(0, 0, 6554, 0, 0, 655360);
		check(32'd65536, 32'd65536, 0, 32'd131072, 32'd65536, 0);
		drain();

		// random phases over several map settings
		configure(-32'sd655360, -32'sd327680, 6554, 256, 256, 655360);
		random_phase(150);
		configure(32'h8000_0000, 32'h7FF0_0000, 65536, 1, 256, 32'h7FFF_FFFF);
		random_phase(80);
		configure(0, 0, 3277, 200, 100, 500000);
		random_phase(150);
		configure(100, 200, 13108, 16, 16, 32'd1310720);
		random_phase(120);
		// hold off until every result is in
		drain();
		configure(0, 0, 6554, 256, 256, 0);
		random_phase(30);
		configure(0, 0, 6554, 256, 256, 655360);
		random_phase(120);

		drain();
		if (mismatches == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

endmodule
